FILE: hw/rtl/stream_slot_assign_lru_assert.svh
// Assertion helpers for the slot table checker.
`ifndef STREAM_SLOT_ASSIGN_LRU_ASSERT_SVH
`define STREAM_SLOT_ASSIGN_LRU_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define SSLRU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("slot table assertion failed");

// Next-cycle implication, disabled while in reset.
`define SSLRU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("slot table assertion failed");

`endif

FILE: hw/rtl/sslru_pkg.sv
`default_nettype none

package sslru_pkg;

    localparam int DEVICE_ID_W = 64;
    localparam int CAMERA_W    = 8;
    localparam int FRAME_W     = 32;
    localparam int SLOT_W      = 3;
    localparam int DEF_SLOTS   = 8;

    // entry layout: {device id, camera, last-use frame}
    localparam int ENTRY_W = DEVICE_ID_W + CAMERA_W + FRAME_W;

    typedef struct packed {
        logic load;     // capture request, clear oldest tracker
        logic scan;     // entry at scan index is on the read port
        logic wr_hit;   // restamp matched entry
        logic wr_miss;  // overwrite oldest entry
    } t_ctrl_cmd;

    typedef struct packed {
        logic match;    // scanned entry carries the request tag
    } t_dp_status;

endpackage

`default_nettype wire

FILE: hw/rtl/sslru_ram.sv
`default_nettype none

module sslru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hw/rtl/sslru_ctrl.sv
`default_nettype none

module sslru_ctrl
    import sslru_pkg::*;
#(
    parameter int SLOTS = DEF_SLOTS,
    parameter int IDX_W = $clog2(DEF_SLOTS)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire t_dp_status       i_status,
    output t_ctrl_cmd             o_cmd,
    output logic      [IDX_W-1:0] o_idx,
    output logic      [IDX_W-1:0] o_raddr,
    output logic                  o_valid
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_MISS = 2'd2;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_done, n_done;
    logic             w_last;

    assign w_last = (r_idx == LAST_IDX);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_done  = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_idx      = '0;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.match) begin
                    o_cmd.wr_hit = 1'b1;
                    n_done       = 1'b1;
                    n_state      = S_IDLE;
                end else if (w_last) begin
                    n_state = S_MISS;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_MISS: begin
                o_cmd.wr_miss = 1'b1;
                n_done        = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // read one entry ahead of the compare
    assign o_raddr = (r_state == S_SCAN && !w_last) ? r_idx + 1'b1 : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_done  <= n_done;
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_idx   = r_idx;
    assign o_valid = r_done;

endmodule

`default_nettype wire

FILE: hw/rtl/sslru_dp.sv
`default_nettype none

module sslru_dp
    import sslru_pkg::*;
#(
    parameter int SLOTS = DEF_SLOTS,
    parameter int IDX_W = $clog2(DEF_SLOTS)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_ctrl_cmd              i_cmd,
    input  wire logic [IDX_W-1:0]       i_idx,
    input  wire logic [IDX_W-1:0]       i_raddr,
    input  wire logic [DEVICE_ID_W-1:0] i_device_id,
    input  wire logic [CAMERA_W-1:0]    i_camera_number,
    input  wire logic [FRAME_W-1:0]     i_frame_count,
    output t_dp_status                  o_status,
    output logic      [SLOT_W-1:0]      o_slot,
    output logic                        o_hit
);

    logic [DEVICE_ID_W-1:0] r_id;
    logic [CAMERA_W-1:0]    r_cam;
    logic [FRAME_W-1:0]     r_now;
    logic [FRAME_W-1:0]     r_worst;
    logic [IDX_W-1:0]       r_victim;
    logic [SLOTS-1:0]       r_valid;
    logic [SLOT_W-1:0]      r_slot;
    logic                   r_hit;

    logic [ENTRY_W-1:0]      w_rdata;
    logic [ENTRY_W-1:0]      w_entry;
    logic [DEVICE_ID_W-1:0]  w_ent_id;
    logic [CAMERA_W-1:0]     w_ent_cam;
    logic [FRAME_W-1:0]      w_ent_stamp;
    logic [FRAME_W-1:0]      w_age;
    logic                    w_we;
    logic [IDX_W-1:0]        w_waddr;
    logic [IDX_W+SLOT_W-1:0] w_slot_wide;

    assign w_we    = i_cmd.wr_hit | i_cmd.wr_miss;
    assign w_waddr = i_cmd.wr_hit ? i_idx : r_victim;

    // a hit rewrites the same tag, so both writes carry the request word
    sslru_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata ({r_id, r_cam, r_now}),
        .i_raddr (i_raddr),
        .o_rdata (w_rdata)
    );

    // never-written entries read as the reset value (all zeros)
    assign w_entry     = r_valid[i_idx] ? w_rdata : '0;
    assign w_ent_stamp = w_entry[FRAME_W-1:0];
    assign w_ent_cam   = w_entry[FRAME_W +: CAMERA_W];
    assign w_ent_id    = w_entry[FRAME_W+CAMERA_W +: DEVICE_ID_W];

    assign w_age          = r_now - w_ent_stamp;
    assign o_status.match = (w_ent_id == r_id) && (w_ent_cam == r_cam);

    assign w_slot_wide = {{SLOT_W{1'b0}}, w_waddr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_we) begin
            r_valid[w_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_id     <= i_device_id;
            r_cam    <= i_camera_number;
            r_now    <= i_frame_count;
            r_worst  <= '0;
            r_victim <= '0;
        end else if (i_cmd.scan && (w_age >= r_worst)) begin
            // ties go to the later index
            r_worst  <= w_age;
            r_victim <= i_idx;
        end
        if (w_we) begin
            r_slot <= w_slot_wide[SLOT_W-1:0];
            r_hit  <= i_cmd.wr_hit;
        end
    end

    assign o_slot = r_slot;
    assign o_hit  = r_hit;

endmodule

`default_nettype wire

FILE: hw/rtl/stream_slot_assign_lru.sv
// Stream slot table: maps a (device id, camera number) tag onto one of SLOTS
// output slots, replacing the least recently used slot on a miss.
//
// Request channel: drive i_device_id, i_camera_number, i_frame_count and
// raise start; the transfer happens at the edge where start is high and busy
// is low. busy stays high while the table is scanned.
// Result channel: o_slot and o_hit are valid for exactly one cycle while
// o_valid is high; the receiver cannot stall, so it must take the transfer.
//
// Sequence: entries are read one per cycle through the table RAM's registered
// read port; a hit on slot k is written back at the end of the scan of slot k
// and a miss after the whole table is scanned, in an extra replace state that
// overwrites the oldest slot. o_valid is high in the cycle after the write-back
// and busy is already low then, so the next request may transfer at the edge
// that ends the o_valid cycle; no request is taken while busy is high.
//
// Reset (synchronous, active low): controller returns to idle and every slot
// reads as device 0, camera 0, last use frame 0; no clearing pass is needed.
`default_nettype none

module stream_slot_assign_lru
    import sslru_pkg::*;
#(
    parameter int SLOTS = DEF_SLOTS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [DEVICE_ID_W-1:0] i_device_id,
    input  wire logic [CAMERA_W-1:0]    i_camera_number,
    input  wire logic [FRAME_W-1:0]     i_frame_count,
    output logic                        o_valid,
    output logic      [SLOT_W-1:0]      o_slot,
    output logic                        o_hit
);

    localparam int IDX_W = $clog2(SLOTS);

    t_ctrl_cmd        w_cmd;
    t_dp_status       w_status;
    logic [IDX_W-1:0] w_idx;
    logic [IDX_W-1:0] w_raddr;

    // sequencer: idle -> scan (one slot per cycle) -> optional replace
    sslru_ctrl #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_idx    (w_idx),
        .o_raddr  (w_raddr),
        .o_valid  (o_valid)
    );

    // table RAM, tag compare, age tracking and result registers
    sslru_dp #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_idx           (w_idx),
        .i_raddr         (w_raddr),
        .i_device_id     (i_device_id),
        .i_camera_number (i_camera_number),
        .i_frame_count   (i_frame_count),
        .o_status        (w_status),
        .o_slot          (o_slot),
        .o_hit           (o_hit)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/sslru_checker.sv
`default_nettype none

`include "stream_slot_assign_lru_assert.svh"

module sslru_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_valid
);

    // a taken request always occupies the table in the next cycle
    `SSLRU_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)

    // results only appear once the scan has finished
    `SSLRU_ASSERT_NOW(a_valid_idle, i_clk, i_rst_n, o_valid, !busy)

    // one result per request, never two in a row
    `SSLRU_ASSERT_NEXT(a_valid_single, i_clk, i_rst_n, o_valid, !o_valid)

    // every end of a scan outside reset delivers a result
    `SSLRU_ASSERT_NOW(a_done_valid, i_clk, i_rst_n, $fell(busy) && $past(i_rst_n), o_valid)

endmodule

bind stream_slot_assign_lru sslru_checker u_sslru_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid)
);

`default_nettype wire
